### rtl/obu_shf_pkg.sv
// ----------------------------------------------------------------------------
// obu_shf_pkg
// Shared types and constants for the OBU sequence header finder: parse
// phases, result cause codes and the fixed field widths.
// ----------------------------------------------------------------------------
package obu_shf_pkg;

  // Default sizing of the buffer position counter and the LEB128 size field
  localparam longint unsigned MAX_BUFFER_BYTES_DEF = 64'd16777216;
  localparam int unsigned     MAX_SIZE_BYTES_DEF   = 8;

  // Fixed result field widths
  localparam int unsigned START_W = 24;
  localparam int unsigned TOTAL_W = 57;
  localparam int unsigned HLEN_W  = 2;

  // Header length values
  localparam logic [HLEN_W-1:0] HLEN_PLAIN = 2'd1;
  localparam logic [HLEN_W-1:0] HLEN_EXT   = 2'd2;

  // OBU type of a sequence header
  localparam logic [3:0] OBU_SEQ_HEADER = 4'd1;

  // Parse phase of the byte scanner
  typedef enum logic [2:0] {
    PH_HEADER     = 3'd0,
    PH_EXT        = 3'd1,
    PH_SIZE       = 3'd2,
    PH_SKIP       = 3'd3,
    PH_RUN        = 3'd4,
    PH_DRAIN_NONE = 3'd5,
    PH_DONE       = 3'd6
  } phase_t;

  // Result cause codes
  typedef enum logic [1:0] {
    CAUSE_FOUND     = 2'd0,
    CAUSE_NONE      = 2'd1,
    CAUSE_FORBIDDEN = 2'd2,
    CAUSE_TRUNCATED = 2'd3
  } cause_t;

endpackage

### rtl/obu_sequence_header_finder.sv
// ----------------------------------------------------------------------------
// obu_sequence_header_finder
// Scans a buffer of AV1 OBUs one byte per transfer, decodes each OBU header
// and LEB128 size, skips payloads and reports the first sequence header OBU.
// ----------------------------------------------------------------------------
// Latency: a result is shown in the cycle after the byte transfer that
//   completes it (one register between the byte and the result port).
// Throughput: one byte per cycle; the parse state updates in a single pass.
//   A waiting result holds the byte channel until its own transfer cycle.
// Reset: clears the parse state to "expect OBU header" at position zero and
//   empties the result register. The state also returns there after a last byte.
module obu_sequence_header_finder
  import obu_shf_pkg::*;
#(
  parameter longint unsigned MAX_BUFFER_BYTES = MAX_BUFFER_BYTES_DEF,
  parameter int unsigned     MAX_SIZE_BYTES   = MAX_SIZE_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // byte channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               found,
  output logic [1:0]         cause,
  output logic [START_W-1:0] start_offset,
  output logic [TOTAL_W-1:0] total_length
);

  localparam int unsigned POS_W = $clog2(MAX_BUFFER_BYTES);
  localparam int unsigned ACC_W = 7 * MAX_SIZE_BYTES;
  localparam int unsigned CNT_W = $clog2(MAX_SIZE_BYTES + 1);
  localparam logic [POS_W:0]   POS_MOD  = (POS_W + 1)'(MAX_BUFFER_BYTES);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_BUFFER_BYTES - 64'd1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_SIZE_BYTES);

  // Parse state registers
  phase_t             phase, phase_next;
  logic [POS_W-1:0]   pos, pos_next;
  logic [POS_W-1:0]   obu_start, obu_start_next;
  logic               target_seen, target_seen_next;
  logic               size_seen, size_seen_next;
  logic [HLEN_W-1:0]  hdr_len, hdr_len_next;
  logic [ACC_W-1:0]   size_acc, size_acc_next;
  logic [CNT_W-1:0]   size_cnt, size_cnt_next;
  logic [TOTAL_W-1:0] remaining, remaining_next;

  // Result of the current byte
  logic               res_fire;
  logic               res_found;
  cause_t             res_cause;
  logic [POS_W-1:0]   res_start;
  logic [TOTAL_W-1:0] res_total;

  logic               in_fire;
  logic               size_done;
  logic [POS_W:0]     run_diff;
  logic [TOTAL_W-1:0] run_len;
  logic [31:0]        res_start_wide;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Next parse state and result for one byte
  always_comb begin
    phase_next       = phase;
    obu_start_next   = obu_start;
    target_seen_next = target_seen;
    size_seen_next   = size_seen;
    hdr_len_next     = hdr_len;
    size_acc_next    = size_acc;
    size_cnt_next    = size_cnt;
    remaining_next   = remaining;
    pos_next         = (pos == POS_LAST) ? '0 : pos + 1'b1;
    res_fire         = 1'b0;
    res_found        = 1'b0;
    res_cause        = CAUSE_NONE;
    res_start        = '0;
    res_total        = '0;
    size_done        = 1'b0;
    run_diff         = '0;
    run_len          = '0;

    case (phase)
      PH_HEADER: begin
        obu_start_next = pos;
        if (data_byte[7]) begin
          res_fire   = 1'b1;
          res_cause  = CAUSE_FORBIDDEN;
          phase_next = PH_DONE;
        end else begin
          target_seen_next = (data_byte[6:3] == OBU_SEQ_HEADER);
          size_seen_next   = data_byte[1];
          if (data_byte[2]) begin
            hdr_len_next = HLEN_EXT;
            phase_next   = PH_EXT;
          end else begin
            hdr_len_next = HLEN_PLAIN;
            if (data_byte[1]) begin
              size_acc_next = '0;
              size_cnt_next = '0;
              phase_next    = PH_SIZE;
            end else if (data_byte[6:3] == OBU_SEQ_HEADER) begin
              phase_next = PH_RUN;
            end else begin
              phase_next = PH_DRAIN_NONE;
            end
          end
        end
      end
      PH_EXT: begin
        if (size_seen) begin
          size_acc_next = '0;
          size_cnt_next = '0;
          phase_next    = PH_SIZE;
        end else if (target_seen) begin
          phase_next = PH_RUN;
        end else begin
          phase_next = PH_DRAIN_NONE;
        end
      end
      PH_SIZE: begin
        // OR the seven payload bits into the lane picked by the byte count
        for (int i = 0; i < MAX_SIZE_BYTES; i++) begin
          if (size_cnt == CNT_W'(i)) begin
            size_acc_next[7*i +: 7] = size_acc[7*i +: 7] | data_byte[6:0];
          end
        end
        size_cnt_next = size_cnt + 1'b1;
        size_done     = !data_byte[7] || (size_cnt_next >= CNT_MAX);
        if (size_done) begin
          if (target_seen) begin
            res_fire   = 1'b1;
            res_found  = 1'b1;
            res_cause  = CAUSE_FOUND;
            res_start  = obu_start;
            res_total  = TOTAL_W'(hdr_len) + TOTAL_W'(size_cnt_next)
                         + TOTAL_W'(size_acc_next);
            phase_next = PH_DONE;
          end else begin
            remaining_next = TOTAL_W'(size_acc_next);
            phase_next     = (size_acc_next != '0) ? PH_SKIP : PH_HEADER;
          end
        end
      end
      PH_SKIP: begin
        remaining_next = remaining - 1'b1;
        if (remaining == TOTAL_W'(1)) begin
          phase_next = PH_HEADER;
        end
      end
      default: begin
      end
    endcase

    // Length of an unsized OBU up to this byte, wrapping with the position
    if (pos >= obu_start_next) begin
      run_diff = {1'b0, pos} - {1'b0, obu_start_next};
    end else begin
      run_diff = {1'b0, pos} + POS_MOD - {1'b0, obu_start_next};
    end
    run_len = TOTAL_W'(run_diff) + TOTAL_W'(1);

    // Close the buffer on its last byte and return to the reset state
    if (last_byte) begin
      if (!res_fire) begin
        case (phase_next)
          PH_RUN: begin
            res_fire  = 1'b1;
            res_found = 1'b1;
            res_cause = CAUSE_FOUND;
            res_start = obu_start_next;
            res_total = run_len;
          end
          PH_EXT, PH_SIZE: begin
            res_fire  = 1'b1;
            res_cause = CAUSE_TRUNCATED;
          end
          PH_DONE: begin
          end
          default: begin
            res_fire  = 1'b1;
            res_cause = CAUSE_NONE;
          end
        endcase
      end
      phase_next       = PH_HEADER;
      pos_next         = '0;
      obu_start_next   = '0;
      target_seen_next = 1'b0;
      size_seen_next   = 1'b0;
      hdr_len_next     = '0;
      size_acc_next    = '0;
      size_cnt_next    = '0;
      remaining_next   = '0;
    end
  end

  // Parse state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      pos         <= '0;
      obu_start   <= '0;
      target_seen <= 1'b0;
      size_seen   <= 1'b0;
      hdr_len     <= '0;
      size_acc    <= '0;
      size_cnt    <= '0;
      remaining   <= '0;
    end else if (in_fire) begin
      phase       <= phase_next;
      pos         <= pos_next;
      obu_start   <= obu_start_next;
      target_seen <= target_seen_next;
      size_seen   <= size_seen_next;
      hdr_len     <= hdr_len_next;
      size_acc    <= size_acc_next;
      size_cnt    <= size_cnt_next;
      remaining   <= remaining_next;
    end
  end

  assign res_start_wide = 32'(res_start);

  // Result register: load on a byte that completes a result, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= res_fire;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_fire) begin
      found        <= res_found;
      cause        <= res_cause;
      start_offset <= res_start_wide[START_W-1:0];
      total_length <= res_total;
    end
  end

  // A shown result is self-consistent
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (found == (cause == CAUSE_FOUND)))
    else $error("found flag disagrees with cause code");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (start_offset == '0 && total_length == '0))
    else $error("failed result carries offset or length");

  // The last byte of a buffer returns the scanner to its start
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && last_byte) |=> (phase == PH_HEADER && pos == '0))
    else $error("scanner not restarted after last byte");

  // Payload skipping never sits on an empty count
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SKIP) |-> (remaining != '0))
    else $error("skip phase with no payload left");

  // A waiting result is not overwritten by a new byte
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("byte taken while result stalled");

endmodule

### bench/obu_shf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obu_shf_checker
// Watches the byte and result channels of the OBU sequence header finder,
// runs its own byte-by-byte parse of each buffer to predict the one report
// per buffer, and compares every result transfer field by field with the
// oldest predicted report. Hands the mismatch count and the number of
// reports still awaited to the bench top.
// ----------------------------------------------------------------------------
module obu_shf_checker
  import obu_shf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               found,
  input  logic [1:0]         cause,
  input  logic [START_W-1:0] start_offset,
  input  logic [TOTAL_W-1:0] total_length,
  output int                 fails,
  output int                 pending
);

  typedef struct packed {
    logic               found;
    cause_t             cause;
    logic [START_W-1:0] start;
    logic [TOTAL_W-1:0] total;
  } seq_report_t;

  seq_report_t seq_reports[$];
  seq_report_t want;

  // Parse state of the predicted scanner
  phase_t             phase;
  logic [23:0]        pos;
  logic [23:0]        obu_start;
  logic               is_seq;
  logic               has_size;
  logic [HLEN_W-1:0]  hlen;
  logic [55:0]        size_acc;
  logic [3:0]         size_cnt;
  logic [56:0]        skip_left;

  initial begin
    fails   = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    $display("%0t ns: mismatch on %s: got 0x%0h, predicted 0x%0h",
             $time, what, got, exp_val);
    fails++;
  endtask

  task automatic clear_parse();
    phase     = PH_HEADER;
    pos       = '0;
    obu_start = '0;
    is_seq    = 1'b0;
    has_size  = 1'b0;
    hlen      = '0;
    size_acc  = '0;
    size_cnt  = '0;
    skip_left = '0;
  endtask

  // Pick the phase once the header, and any extension byte, is complete
  task automatic header_done();
    if (has_size) begin
      size_acc = '0;
      size_cnt = '0;
      phase    = PH_SIZE;
    end else if (is_seq) begin
      phase = PH_RUN;
    end else begin
      phase = PH_DRAIN_NONE;
    end
  endtask

  // Advance the predicted parse by one byte; queue the report it causes
  task automatic parse_byte(input logic [7:0] b, input logic fin);
    seq_report_t r;
    bit          have;
    logic [23:0] span;
    have = 1'b0;
    r    = '0;
    case (phase)
      PH_HEADER: begin
        obu_start = pos;
        if (b[7]) begin
          r.cause = CAUSE_FORBIDDEN;
          have    = 1'b1;
          phase   = PH_DONE;
        end else begin
          is_seq   = (b[6:3] == OBU_SEQ_HEADER);
          has_size = b[1];
          if (b[2]) begin
            hlen  = HLEN_EXT;
            phase = PH_EXT;
          end else begin
            hlen = HLEN_PLAIN;
            header_done();
          end
        end
      end
      PH_EXT: header_done();
      PH_SIZE: begin
        size_acc = size_acc | ({49'd0, b[6:0]} << (7 * size_cnt[2:0]));
        size_cnt = size_cnt + 4'd1;
        // a long size ends after its last allowed byte, continuation or not
        if (!b[7] || 32'(size_cnt) >= MAX_SIZE_BYTES_DEF) begin
          if (is_seq) begin
            r.found = 1'b1;
            r.cause = CAUSE_FOUND;
            r.start = obu_start;
            r.total = {55'd0, hlen} + {53'd0, size_cnt} + {1'b0, size_acc};
            have    = 1'b1;
            phase   = PH_DONE;
          end else begin
            skip_left = {1'b0, size_acc};
            phase     = (skip_left != '0) ? PH_SKIP : PH_HEADER;
          end
        end
      end
      PH_SKIP: begin
        skip_left = skip_left - 57'd1;
        if (skip_left == '0) phase = PH_HEADER;
      end
      default: ;
    endcase

    if (fin) begin
      if (!have) begin
        have = 1'b1;
        case (phase)
          PH_RUN: begin
            // an unsized sequence header runs up to the final byte
            span    = pos - obu_start;
            r.found = 1'b1;
            r.cause = CAUSE_FOUND;
            r.start = obu_start;
            r.total = {33'd0, span} + 57'd1;
          end
          PH_EXT, PH_SIZE: r.cause = CAUSE_TRUNCATED;
          PH_DONE:         have = 1'b0;
          default:         r.cause = CAUSE_NONE;
        endcase
      end
      clear_parse();
    end else begin
      pos = pos + 24'd1;
    end
    if (have) seq_reports.push_back(r);
  endtask

  // Compare result transfers first, then fold in the byte transfer
  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      seq_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (seq_reports.size() == 0) begin
          report_mismatch("unexpected result, cause", 64'(cause), 64'(0));
        end else begin
          want = seq_reports.pop_front();
          if (found !== want.found)
            report_mismatch("found", 64'(found), 64'(want.found));
          if (cause !== want.cause)
            report_mismatch("cause", 64'(cause), 64'(want.cause));
          if (start_offset !== want.start)
            report_mismatch("start_offset", 64'(start_offset), 64'(want.start));
          if (total_length !== want.total)
            report_mismatch("total_length", 64'(total_length), 64'(want.total));
        end
      end
      if (in_valid && in_ready) parse_byte(data_byte, last_byte);
    end
    pending = seq_reports.size();
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the OBU sequence header finder: sends short directed buffers
// covering each outcome, then random buffers built mostly from well-formed
// OBU chains (padded and long LEB128 sizes, extension bytes, unsized OBUs)
// with some truncated, forbidden and noise buffers. Both channels idle at
// random; the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top
  import obu_shf_pkg::*;
();

  localparam int STALL_LIMIT = 3000;
  localparam int BYTE_TARGET = 1400;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         data_byte;
  logic               last_byte;
  logic               out_valid;
  logic               out_ready;
  logic               found;
  logic [1:0]         cause;
  logic [START_W-1:0] start_offset;
  logic [TOTAL_W-1:0] total_length;

  int                 fail_count;
  int                 awaited;
  int                 sent;
  int                 stall_cycles;
  bit                 calm;
  logic [7:0]         buf_q[$];

  obu_sequence_header_finder u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .cause        (cause),
    .start_offset (start_offset),
    .total_length (total_length)
  );

  obu_shf_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .cause        (cause),
    .start_offset (start_offset),
    .total_length (total_length),
    .fails        (fail_count),
    .pending      (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: stall at random except during the calm stretch
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= calm || ($urandom_range(0, 99) >= 28);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    stall_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic logic [7:0] obu_hdr(input logic forb, input logic [3:0] typ,
                                         input logic ext, input logic sized,
                                         input logic rsv);
    return {forb, typ, ext, sized, rsv};
  endfunction

  // Append one OBU: header, optional extension, LEB128 size, payload bytes
  task automatic add_obu(input logic [3:0] typ, input logic sized,
                         input logic [55:0] size_val, input int pay_len);
    logic        ext;
    logic [55:0] rest;
    logic [7:0]  grp;
    int          min_bytes;
    int          n_bytes;
    ext = ($urandom_range(0, 3) == 0);
    buf_q.push_back(obu_hdr(1'b0, typ, ext, sized, 1'($urandom_range(0, 1))));
    if (ext) buf_q.push_back(8'($urandom_range(0, 255)));
    if (sized) begin
      min_bytes = 1;
      rest      = size_val >> 7;
      while (rest != '0) begin
        min_bytes++;
        rest = rest >> 7;
      end
      // pad the size now and then with zero continuation groups
      n_bytes = ($urandom_range(0, 3) == 0) ? $urandom_range(min_bytes, 8) : min_bytes;
      for (int i = 0; i < n_bytes; i++) begin
        grp = {1'b0, size_val[7*i +: 7]};
        if (i < n_bytes - 1 || (n_bytes == 8 && $urandom_range(0, 1) == 1))
          grp[7] = 1'b1;
        buf_q.push_back(grp);
      end
    end
    repeat (pay_len) buf_q.push_back(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [55:0] seq_size();
    logic [63:0] wide;
    case ($urandom_range(0, 3))
      0:       return 56'($urandom_range(0, 20));
      1:       return {24'd0, 32'($urandom)};
      2: begin
        wide = {32'($urandom), 32'($urandom)};
        return wide[55:0];
      end
      default: return '1;
    endcase
  endfunction

  // Build one random buffer, mostly a well-formed chain of OBUs
  task automatic build_buffer();
    int          n_other;
    int          cut;
    logic [3:0]  typ;
    logic [55:0] sz;
    bit          stop;
    buf_q.delete();
    stop = 1'b0;
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 10)) buf_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    n_other = $urandom_range(0, 3);
    for (int k = 0; k < n_other && !stop; k++) begin
      typ = 4'($urandom_range(0, 15));
      if (typ == OBU_SEQ_HEADER) typ = typ + 4'd1;
      case ($urandom_range(0, 19))
        0: begin
          buf_q.push_back(obu_hdr(1'b1, typ, 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
          stop = 1'b1;
        end
        1: begin
          // unsized: runs to the end of the buffer
          add_obu(typ, 1'b0, '0, $urandom_range(0, 6));
          stop = 1'b1;
        end
        2: begin
          // buffer ends inside the payload
          add_obu(typ, 1'b1, 56'($urandom_range(7, 400)), $urandom_range(0, 5));
          stop = 1'b1;
        end
        default: begin
          sz = 56'($urandom_range(0, 6));
          add_obu(typ, 1'b1, sz, int'(sz));
        end
      endcase
    end
    if (!stop && $urandom_range(0, 9) < 8) begin
      if ($urandom_range(0, 3) != 0)
        add_obu(OBU_SEQ_HEADER, 1'b1, seq_size(), $urandom_range(0, 3));
      else
        add_obu(OBU_SEQ_HEADER, 1'b0, '0, $urandom_range(0, 8));
    end
    if (buf_q.size() == 0) buf_q.push_back(8'($urandom_range(0, 255)));
    // cut short now and then: truncated headers and sizes
    if ($urandom_range(0, 99) < 20) begin
      cut = $urandom_range(1, buf_q.size());
      while (buf_q.size() > cut) void'(buf_q.pop_back());
    end
  endtask

  // Offer one byte, idling first at random; return once transferred
  task automatic send_byte(input logic [7:0] b, input logic fin);
    logic taken;
    if (!calm) begin
      while ($urandom_range(0, 99) < 28) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    sent++;
  endtask

  task automatic send_buffer();
    for (int i = 0; i < buf_q.size(); i++)
      send_byte(buf_q[i], i == buf_q.size() - 1);
  endtask

  // Hold the byte channel until every predicted report has arrived
  task automatic drain_reports();
    in_valid <= 1'b0;
    do @(negedge clk); while (awaited != 0);
    @(posedge clk);
  endtask

  initial begin
    int nbuf;
    rst       = 1'b1;
    in_valid  = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    calm      = 1'b0;
    sent      = 0;
    nbuf      = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: short buffers that together cover each outcome
    buf_q = '{obu_hdr(1'b0, OBU_SEQ_HEADER, 1'b0, 1'b0, 1'b0)};
    send_buffer();
    buf_q = '{8'h80};
    send_buffer();
    buf_q = '{obu_hdr(1'b0, 4'd3, 1'b1, 1'b1, 1'b0)};
    send_buffer();
    buf_q = '{obu_hdr(1'b0, OBU_SEQ_HEADER, 1'b0, 1'b1, 1'b0)};
    send_buffer();
    // widest size, continuation still set on the eighth byte
    buf_q = '{obu_hdr(1'b0, OBU_SEQ_HEADER, 1'b0, 1'b1, 1'b1),
              8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_buffer();
    buf_q = '{obu_hdr(1'b0, 4'd2, 1'b0, 1'b1, 1'b0), 8'h00,
              obu_hdr(1'b0, OBU_SEQ_HEADER, 1'b1, 1'b1, 1'b0), 8'hFF, 8'h00};
    send_buffer();
    buf_q = '{obu_hdr(1'b0, 4'd2, 1'b0, 1'b0, 1'b0), 8'h55, 8'hAA};
    send_buffer();
    buf_q = '{obu_hdr(1'b0, 4'd2, 1'b0, 1'b1, 1'b0), 8'h01, 8'h00};
    send_buffer();
    buf_q = '{obu_hdr(1'b0, 4'd15, 1'b0, 1'b1, 1'b0), 8'h80};
    send_buffer();
    drain_reports();

    // Random buffers, with a calm stretch and periodic drains
    while (sent < BYTE_TARGET) begin
      calm = (sent >= 500 && sent < 800);
      build_buffer();
      send_buffer();
      nbuf++;
      if (nbuf % 25 == 10) drain_reports();
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (awaited != 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && awaited == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
